FILE: src/assert_macros.svh
// Assertion helpers used by the fusion top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/tvwf_pkg.sv
package tvwf_pkg;

    localparam int IDX_W = 15;
    localparam int VAL_W = 16;
    localparam int DIV_W = 32;
    localparam int VOXEL_COUNT_DEF = 32768;

    localparam logic signed [VAL_W-1:0] DIST_MINUS_ONE = -16'sd32767;
    localparam logic signed [VAL_W-1:0] DIST_MOST_NEG = -16'sd32768;
    localparam logic [VAL_W-1:0] WEIGHT_MAX = 16'hFFFF;

    // Request kinds carried in s_tuser.
    localparam logic REQ_FUSE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // One voxel as it lives in the store.
    typedef struct packed {
        logic [VAL_W-1:0]        blue;
        logic [VAL_W-1:0]        green;
        logic [VAL_W-1:0]        red;
        logic [VAL_W-1:0]        weight;
        logic signed [VAL_W-1:0] distance;
    } voxel_t;

    localparam voxel_t VOXEL_RESET = '{blue: '0, green: '0, red: '0, weight: '0,
                                       distance: DIST_MINUS_ONE};

endpackage

FILE: src/tsdf_voxel_weighted_fusion.sv
// TSDF voxel fusion by running weighted average. Each request (fuse or read,
// selected by s_tuser) answers with exactly one result holding the voxel after
// the request. Requests are handled one at a time, in the states accept (which
// also starts the index modulo by a reciprocal multiply), modulo correction,
// memory read, multiply, divider load, divide (32 bit-serial steps) and
// write-back, which waits while the master side stalls. Reads, ignored fuses
// and fuses without a valid sample go from the multiply straight to the
// write-back. A new request is taken while the previous result still waits
// on the master side.
// After reset the store is cleared one voxel per cycle; no request is
// accepted until the sweep ends.
`include "assert_macros.svh"

module tsdf_voxel_weighted_fusion #(
    parameter int VOXEL_COUNT = tvwf_pkg::VOXEL_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // voxel_index[14:0], sample_distance[30:15], sample_valid[31],
    // sample_red[39:32], sample_green[47:40], sample_blue[55:48]
    input  logic [55:0] s_tdata,
    // req_type[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_index[14:0], fused_distance[30:15], fused_weight[46:31],
    // fused_red[62:47], fused_green[78:63], fused_blue[94:79], zero[95]
    output logic [95:0] m_tdata
);

    localparam int AW = (VOXEL_COUNT > 1) ? $clog2(VOXEL_COUNT) : 1;
    localparam int IW = tvwf_pkg::IDX_W;
    localparam int VW = tvwf_pkg::VAL_W;
    localparam int DW = tvwf_pkg::DIV_W;
    localparam int MW = IW + AW + 1;
    localparam int MOD_SH = IW + AW;
    localparam logic [IW:0] MOD_RECIP = (IW + 1)'((longint'(1) << MOD_SH) / VOXEL_COUNT);
    localparam logic [MW-1:0] COUNT_C = MW'(VOXEL_COUNT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(VOXEL_COUNT - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MOD, S_RD, S_MUL, S_START, S_DIV, S_FIN
    } state_t;

    state_t state_reg;

    // Request fields.
    logic                    req_reg;
    logic [IW-1:0]           idx_reg;
    logic signed [VW-1:0]    sd_reg;
    logic                    add_reg;
    logic [7:0]              red_in_reg;
    logic [7:0]              green_in_reg;
    logic [7:0]              blue_in_reg;

    logic [2*IW:0]           modq_reg;
    logic [AW-1:0]           rem_reg;
    logic [AW-1:0]           clr_reg;

    tvwf_pkg::voxel_t        mem [VOXEL_COUNT];
    tvwf_pkg::voxel_t        mem_q_reg;
    tvwf_pkg::voxel_t        old_reg;
    tvwf_pkg::voxel_t        res_reg;
    logic                    do_write_reg;

    logic signed [2*VW:0]    prod_d_reg;
    logic [DW-1:0]           prod_r_reg;
    logic [DW-1:0]           prod_g_reg;
    logic [DW-1:0]           prod_b_reg;
    logic                    neg_reg;

    logic                    m_tvalid_reg;
    logic [95:0]             m_tdata_reg;

    // Memory ports.
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    tvwf_pkg::voxel_t        mem_wdata;
    logic [AW-1:0]           mem_raddr;

    // Divider lanes.
    logic                    div_start;
    logic [DW-1:0]           dvd_d;
    logic [DW-1:0]           dvd_r;
    logic [DW-1:0]           dvd_g;
    logic [DW-1:0]           dvd_b;
    logic [VW-1:0]           divisor;
    logic                    div_done;
    logic                    done_r;
    logic                    done_g;
    logic                    done_b;
    logic [VW-1:0]           q_d;
    logic [VW-1:0]           q_r;
    logic [VW-1:0]           q_g;
    logic [VW-1:0]           q_b;
    logic signed [2*VW:0]    num_d;
    logic signed [2*VW:0]    mag_d;

    // Index modulo.
    logic [IW-1:0]           mod_q;
    logic [MW-1:0]           mod_qn;
    logic [MW-1:0]           mod_raw;
    logic [MW-1:0]           mod_rem;

    logic                    out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Index modulo the store size: the reciprocal estimate is low by at most
    // one, so a single compare and subtract finishes it.
    always_comb begin
        mod_q   = IW'(modq_reg >> MOD_SH);
        mod_qn  = MW'(mod_q) * COUNT_C;
        mod_raw = MW'(idx_reg) - mod_qn;
        mod_rem = (mod_raw >= COUNT_C) ? mod_raw - COUNT_C : mod_raw;
    end

    // Numerators for the dividers: product plus the weighted sample.
    always_comb begin
        num_d   = prod_d_reg + (2*VW+1)'(sd_reg);
        mag_d   = num_d[2*VW] ? -num_d : num_d;
        dvd_d   = mag_d[DW-1:0];
        dvd_r   = prod_r_reg + {16'd0, red_in_reg, 8'd0};
        dvd_g   = prod_g_reg + {16'd0, green_in_reg, 8'd0};
        dvd_b   = prod_b_reg + {16'd0, blue_in_reg, 8'd0};
        divisor = old_reg.weight + 1'b1;
        div_start = (state_reg == S_START);
    end

    // Write port: clearing sweep after reset, write-back at the end of a fuse.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = rem_reg;
        mem_wdata = res_reg;
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = tvwf_pkg::VOXEL_RESET;
        end else if (state_reg == S_FIN && out_free && do_write_reg) begin
            mem_we = 1'b1;
        end
        mem_raddr = rem_reg;
    end

    // Voxel store.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_raddr];
    end

    // Sequencer for one request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            do_write_reg <= 1'b0;
        end else begin
            // Result register: loaded out of the final state, dropped when taken.
            if (state_reg == S_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST_ADDR) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        req_reg      <= s_tuser[0];
                        idx_reg      <= s_tdata[14:0];
                        modq_reg     <= s_tdata[14:0] * MOD_RECIP;
                        sd_reg       <= (s_tdata[30:15] == tvwf_pkg::DIST_MOST_NEG) ?
                                        tvwf_pkg::DIST_MINUS_ONE : s_tdata[30:15];
                        add_reg      <= s_tdata[31];
                        red_in_reg   <= s_tdata[39:32];
                        green_in_reg <= s_tdata[47:40];
                        blue_in_reg  <= s_tdata[55:48];
                        state_reg    <= S_MOD;
                    end
                end
                S_MOD: begin
                    rem_reg   <= mod_rem[AW-1:0];
                    state_reg <= S_RD;
                end
                S_RD: begin
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    old_reg    <= mem_q_reg;
                    prod_d_reg <= mem_q_reg.distance * $signed({1'b0, mem_q_reg.weight});
                    prod_r_reg <= mem_q_reg.red * mem_q_reg.weight;
                    prod_g_reg <= mem_q_reg.green * mem_q_reg.weight;
                    prod_b_reg <= mem_q_reg.blue * mem_q_reg.weight;
                    res_reg    <= mem_q_reg;
                    if (req_reg == tvwf_pkg::REQ_READ ||
                        mem_q_reg.weight == tvwf_pkg::WEIGHT_MAX) begin
                        do_write_reg <= 1'b0;
                        state_reg    <= S_FIN;
                    end else if (!add_reg) begin
                        // Without a sample the average stays; an empty voxel
                        // is forced back to minus one.
                        do_write_reg <= 1'b1;
                        if (mem_q_reg.weight == '0) begin
                            res_reg.distance <= tvwf_pkg::DIST_MINUS_ONE;
                        end
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_START;
                    end
                end
                S_START: begin
                    neg_reg   <= num_d[2*VW];
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        res_reg.distance <= neg_reg ? -$signed(q_d) : $signed(q_d);
                        res_reg.weight   <= divisor;
                        res_reg.red      <= q_r;
                        res_reg.green    <= q_g;
                        res_reg.blue     <= q_b;
                        do_write_reg     <= 1'b1;
                        state_reg        <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        m_tdata_reg  <= {1'b0, res_reg.blue, res_reg.green, res_reg.red,
                                         res_reg.weight, res_reg.distance, idx_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    tvwf_div u_div_d (.aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(dvd_d),
                      .divisor(divisor), .done(div_done), .quotient(q_d));
    tvwf_div u_div_r (.aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(dvd_r),
                      .divisor(divisor), .done(done_r), .quotient(q_r));
    tvwf_div u_div_g (.aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(dvd_g),
                      .divisor(divisor), .done(done_g), .quotient(q_g));
    tvwf_div u_div_b (.aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(dvd_b),
                      .divisor(divisor), .done(done_b), .quotient(q_b));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A new result only appears out of the final state.
    `ASSERT_CLK(a_result_from_fin, aclk, aresetn,
                $rose(m_tvalid_reg) |-> $past(state_reg == S_FIN), "result out of sequence")
    // The store is only written by the clearing sweep or a write-back.
    `ASSERT_CLK(a_write_source, aclk, aresetn,
                mem_we |-> (state_reg == S_CLEAR || state_reg == S_FIN),
                "unexpected store write")
    // A fuse never lowers the weight of a voxel.
    `ASSERT_CLK(a_weight_grows, aclk, aresetn,
                (state_reg == S_FIN && do_write_reg) |-> (res_reg.weight >= old_reg.weight),
                "weight decreased")
    // All divider lanes finish together.
    `ASSERT_CLK(a_lanes_aligned, aclk, aresetn,
                div_done |-> (done_r && done_g && done_b), "divider lanes out of step")

endmodule

FILE: src/tvwf_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module tvwf_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [tvwf_pkg::DIV_W-1:0]       dividend,
    input  logic [tvwf_pkg::VAL_W-1:0]       divisor,
    output logic                             done,
    output logic [tvwf_pkg::VAL_W-1:0]       quotient
);

    localparam int DW = tvwf_pkg::DIV_W;
    localparam int VW = tvwf_pkg::VAL_W;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dvd_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   rem_sh;
    logic          ge;
    logic [VW:0]   rem_sub;

    // Shift in the next dividend bit and try a subtraction.
    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[DW-1]};
        ge      = rem_sh >= {1'b0, dsr_reg};
        rem_sub = rem_sh - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
                dvd_reg <= {dvd_reg[DW-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[VW-1:0];

endmodule
